>>> sv/stationary_kernel_eval_core_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef STATIONARY_KERNEL_EVAL_CORE_DEFINES_SVH
`define STATIONARY_KERNEL_EVAL_CORE_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define SKE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SKE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/ske_pkg.sv
package ske_pkg;

   // Default fixed-point format of the distance and the results.
   localparam int FRAC_BITS_DEF = 16;
   localparam int INT_BITS_DEF  = 8;

   // Internal formats: Q.40 for values and Q.46 inside the exponential.
   localparam int IP = 40;
   localparam int EP = 46;
   localparam int MW = 64;

   // Shift of the reciprocal used to divide the series terms.
   localparam int RECIP_SH    = 48;
   localparam int EXP_TERMS   = 16;
   localparam int EXP_SQUARES = 6;

   typedef logic [MW-1:0] word_type;

   localparam word_type ONE_I   = word_type'(1) << IP;
   localparam word_type HALF_I  = word_type'(1) << (IP - 1);
   localparam word_type ONE_E   = word_type'(1) << EP;
   localparam word_type LIMIT_T = word_type'(32) << IP;
   localparam word_type C_SQRT3 = 64'h0000_01BB_67AE_8585;
   localparam word_type C_SQRT5 = 64'h0000_023C_6EF3_72FF;
   localparam word_type C_FIVE3 = 64'h0000_01AA_AAAA_AAAB;

   // Kernel selection codes.
   typedef enum logic [1:0] {
      KIND_SQEXP = 2'd0,
      KIND_EXP   = 2'd1,
      KIND_MAT32 = 2'd2,
      KIND_MAT52 = 2'd3
   } kind_type;

endpackage

>>> sv/stationary_kernel_eval_core.sv
// Stationary covariance kernel evaluator.
// The req channel carries one scaled distance r per transfer (unsigned,
// INT_BITS.FRAC_BITS). The rsp channel returns K(r) and dK/dr for it.
// The csr port selects the kernel: squared exponential, exponential,
// Matern 3/2 or Matern 5/2. Write it only while no item is in flight.
// The block takes one distance every cycle while the output is not stalled.
// A result passes through one input stage, three multiply stages, the
// exponential (sixteen series terms, one subtract, six squarings), a final
// multiply and the output register.
// Distances of 64 and more, and arguments that make the exponential
// underflow, give zero for both value and slope.
// Reset clears the pipeline valid bits and sets the kernel to squared
// exponential. While the receiver holds rsp_tready low with a result
// waiting, the whole pipeline holds and req_tready drops; nothing is lost.
module stationary_kernel_eval_core import ske_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int INT_BITS  = INT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // req_tdata: distance
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((INT_BITS + FRAC_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // rsp_tdata: kernel_value, kernel_slope
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [((2 * FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                          csr_wr_en,
   input  logic [1:0]                                    csr_wr_data
);

   localparam int DW     = INT_BITS + FRAC_BITS;
   localparam int OW     = FRAC_BITS + 1;
   localparam int RSP_W  = ((2 * OW + 7) / 8) * 8;
   localparam int RND_SH = IP - FRAC_BITS;
   localparam word_type RND_HALF = word_type'(1) << (RND_SH - 1);
   localparam word_type ONE_O    = word_type'(1) << FRAC_BITS;

   logic              en;
   kind_type          kind_ff;

   logic              in_valid_ff;
   logic [DW-1:0]     dist_ff;
   kind_type          ikind_ff;
   word_type          r, bsel;
   logic              ovr;

   logic              v1a, v1b, v1c;
   word_type          p_t, p_rr, p_f3r, g1_r;
   logic [1:0]        g1_kind_bits;
   kind_type          g1_kind;
   logic              g1_ovr, g1_valid;
   word_type          t1;
   logic              uf1;

   logic              v2a, v2b, g2_valid;
   word_type          p_sq, p_s3t;
   logic [130:0]      g2_side;
   word_type          g2_f3r;

   logic              g3_valid;
   word_type          p_s5sq;
   logic [322:0]      g3_side;
   kind_type          g3_kind;
   logic              g3_uf;
   word_type          g3_t, g3_r, g3_f3r, g3_s3t, g3_sq;
   word_type          mul_a, mul_b;

   logic              ex_valid;
   word_type          ex_e;
   logic [128:0]      ex_side;

   logic              v4a, v4b, g4_valid, uf_val, uf_slp, g4_uf;
   word_type          p_val, p_slp;
   word_type          val_r, slp_r, val_s, slp_s;
   logic [OW-1:0]     value_in, slope_in, value_ff, slope_ff;
   logic              rsp_valid_ff;

   // The pipeline moves whenever the output register is free or drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Kernel selection register.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_SQEXP;
      end else if (csr_wr_en) begin
         kind_ff <= kind_type'(csr_wr_data);
      end
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff  <= req_tdata[DW-1:0];
         ikind_ff <= kind_ff;
      end
   end

   // Distance in Q.40 and the early range check.
   assign r   = word_type'(dist_ff) << RND_SH;
   assign ovr = 32'(dist_ff >> FRAC_BITS) >= 32'd64;

   always_comb begin
      case (ikind_ff)
         KIND_SQEXP: bsel = r;
         KIND_MAT32: bsel = C_SQRT3;
         default:    bsel = C_SQRT5;
      endcase
   end

   // First multiply group: exponent product, r squared, 5/3 r.
   ske_mul #(.SHIFT(IP), .SIDE_W(2)) u_mt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(in_valid_ff), .a(r), .b(bsel), .in_side(ikind_ff),
      .out_valid(v1a), .prod(p_t), .out_side(g1_kind_bits)
   );

   ske_mul #(.SHIFT(IP), .SIDE_W(MW)) u_mrr (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(in_valid_ff), .a(r), .b(r), .in_side(r),
      .out_valid(v1b), .prod(p_rr), .out_side(g1_r)
   );

   ske_mul #(.SHIFT(IP), .SIDE_W(1)) u_mf3r (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(in_valid_ff), .a(C_FIVE3), .b(r), .in_side(ovr),
      .out_valid(v1c), .prod(p_f3r), .out_side(g1_ovr)
   );

   assign g1_kind  = kind_type'(g1_kind_bits);
   assign g1_valid = v1a && v1b && v1c;

   // Exponent argument and the underflow test.
   always_comb begin
      case (g1_kind)
         KIND_SQEXP: t1 = p_t >> 1;
         KIND_EXP:   t1 = g1_r >> 1;
         default:    t1 = p_t;
      endcase
   end

   assign uf1 = g1_ovr || (t1 >= LIMIT_T);

   // Second multiply group: 5/3 r squared and sqrt3 t.
   ske_mul #(.SHIFT(IP), .SIDE_W(131)) u_msq (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(g1_valid), .a(p_rr), .b(C_FIVE3), .in_side({g1_kind, uf1, t1, g1_r}),
      .out_valid(v2a), .prod(p_sq), .out_side(g2_side)
   );

   ske_mul #(.SHIFT(IP), .SIDE_W(MW)) u_ms3 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(g1_valid), .a(C_SQRT3), .b(t1), .in_side(p_f3r),
      .out_valid(v2b), .prod(p_s3t), .out_side(g2_f3r)
   );

   assign g2_valid = v2a && v2b;

   // Third multiply: sqrt5 times the square term.
   ske_mul #(.SHIFT(IP), .SIDE_W(323)) u_ms5 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(g2_valid), .a(C_SQRT5), .b(p_sq),
      .in_side({g2_side[130:64], g2_side[63:0], g2_f3r, p_s3t, p_sq}),
      .out_valid(g3_valid), .prod(p_s5sq), .out_side(g3_side)
   );

   assign g3_kind = kind_type'(g3_side[322:321]);
   assign g3_uf   = g3_side[320];
   assign g3_t    = g3_side[319:256];
   assign g3_r    = g3_side[255:192];
   assign g3_f3r  = g3_side[191:128];
   assign g3_s3t  = g3_side[127:64];
   assign g3_sq   = g3_side[63:0];

   // Factors that scale the exponential into the value and the slope.
   always_comb begin
      case (g3_kind)
         KIND_SQEXP: begin
            mul_a = ONE_I;
            mul_b = g3_r;
         end
         KIND_EXP: begin
            mul_a = ONE_I;
            mul_b = HALF_I;
         end
         KIND_MAT32: begin
            mul_a = ONE_I + g3_t;
            mul_b = g3_s3t;
         end
         default: begin
            mul_a = ONE_I + g3_t + g3_sq;
            mul_b = p_s5sq + g3_f3r;
         end
      endcase
   end

   ske_exp #(.SIDE_W(129)) u_exp (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(g3_valid), .t(g3_t), .in_side({g3_uf, mul_a, mul_b}),
      .out_valid(ex_valid), .e(ex_e), .out_side(ex_side)
   );

   // Final multiplies by the exponential.
   ske_mul #(.SHIFT(IP), .SIDE_W(1)) u_mval (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(ex_valid), .a(ex_side[127:64]), .b(ex_e), .in_side(ex_side[128]),
      .out_valid(v4a), .prod(p_val), .out_side(uf_val)
   );

   ske_mul #(.SHIFT(IP), .SIDE_W(1)) u_mslp (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(ex_valid), .a(ex_side[63:0]), .b(ex_e), .in_side(ex_side[128]),
      .out_valid(v4b), .prod(p_slp), .out_side(uf_slp)
   );

   assign g4_valid = v4a && v4b;
   assign g4_uf    = uf_val || uf_slp;

   // Round half up to the output format, saturate at one, negate the slope.
   assign val_r = (p_val + RND_HALF) >> RND_SH;
   assign slp_r = (p_slp + RND_HALF) >> RND_SH;
   assign val_s = (val_r > ONE_O) ? ONE_O : val_r;
   assign slp_s = (slp_r > ONE_O) ? ONE_O : slp_r;
   assign value_in = g4_uf ? '0 : val_s[OW-1:0];
   assign slope_in = g4_uf ? '0 : (~slp_s[OW-1:0] + OW'(1));

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= g4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         slope_ff <= slope_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({slope_ff, value_ff});

endmodule

>>> sv/ske_mul.sv
module ske_mul import ske_pkg::*; #(
   parameter int SHIFT  = IP,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  word_type          a,
   input  word_type          b,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output word_type          prod,
   output logic [SIDE_W-1:0] out_side
);

   word_type          ll_in, lh_in, hl_in, hh_in;
   word_type          ll_ff, lh_ff, hl_ff, hh_ff;
   logic [2*MW-1:0]   sum;
   word_type          prod_in, prod_ff;
   logic              v1_ff, v2_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff;

   // First stage: four 32 by 32 partial products.
   assign ll_in = {32'd0, a[31:0]} * {32'd0, b[31:0]};
   assign lh_in = {32'd0, a[31:0]} * {32'd0, b[63:32]};
   assign hl_in = {32'd0, a[63:32]} * {32'd0, b[31:0]};
   assign hh_in = {32'd0, a[63:32]} * {32'd0, b[63:32]};

   // Second stage: add the partial products and take the shifted window.
   assign sum = {hh_ff, 64'd0} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
              + {64'd0, ll_ff};
   assign prod_in = sum[SHIFT +: MW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
         hh_ff    <= hh_in;
         side1_ff <= in_side;
         prod_ff  <= prod_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign prod      = prod_ff;
   assign out_side  = side2_ff;

endmodule

>>> sv/ske_exp.sv
module ske_exp import ske_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  word_type          t,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output word_type          e,
   output logic [SIDE_W-1:0] out_side
);

   // Carried with each term: {x, positive sum, negative sum, side data}.
   localparam int NEG_LO  = SIDE_W;
   localparam int POS_LO  = SIDE_W + MW;
   localparam int X_LO    = SIDE_W + 2 * MW;
   localparam int CARRY_W = SIDE_W + 3 * MW;

   logic                st_valid [0:EXP_TERMS];
   word_type            st_term  [0:EXP_TERMS];
   logic [CARRY_W-1:0]  st_carry [0:EXP_TERMS];

   logic                dv_ff;
   word_type            diff_in, diff_ff;
   logic [SIDE_W-1:0]   dside_ff;

   logic                sq_valid [0:EXP_SQUARES];
   word_type            sq_e     [0:EXP_SQUARES];
   logic [SIDE_W-1:0]   sq_side  [0:EXP_SQUARES];

   // The series starts at one, with x = t read as Q.46.
   assign st_valid[0] = in_valid;
   assign st_term[0]  = ONE_E;
   assign st_carry[0] = {t, ONE_E, word_type'(0), in_side};

   // One series term per section: multiply by x, then divide by k.
   for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
      localparam word_type K     = word_type'(k);
      localparam word_type RECIP = (word_type'(1) << RECIP_SH) / K;
      localparam bit       ODD   = (k % 2) == 1;

      logic                  mv, dv;
      word_type              mp, dq;
      logic [CARRY_W-1:0]    mc;
      logic [CARRY_W+MW-1:0] dc;
      word_type              num, rem, q_in, q_ff, term_ff;
      word_type              pos, neg, pos_in, neg_in;
      logic                  cv_ff, av_ff;
      logic [CARRY_W-1:0]    cc_ff, ac_ff;

      ske_mul #(.SHIFT(EP), .SIDE_W(CARRY_W)) u_mul (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(st_valid[k-1]), .a(st_term[k-1]), .b(st_carry[k-1][X_LO +: MW]),
         .in_side(st_carry[k-1]),
         .out_valid(mv), .prod(mp), .out_side(mc)
      );

      // Quotient estimate by the reciprocal; it is low by at most one.
      ske_mul #(.SHIFT(RECIP_SH), .SIDE_W(CARRY_W + MW)) u_div (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(mv), .a(mp), .b(RECIP), .in_side({mc, mp}),
         .out_valid(dv), .prod(dq), .out_side(dc)
      );

      // Correct the estimate with one compare against the remainder.
      assign num  = dc[MW-1:0];
      assign rem  = num - dq * K;
      assign q_in = (rem >= K) ? dq + word_type'(1) : dq;

      // Odd terms go to the negative sum, even terms to the positive one.
      assign pos    = cc_ff[POS_LO +: MW];
      assign neg    = cc_ff[NEG_LO +: MW];
      assign pos_in = ODD ? pos : pos + q_ff;
      assign neg_in = ODD ? neg + q_ff : neg;

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff <= 1'b0;
            av_ff <= 1'b0;
         end else if (en) begin
            cv_ff <= dv;
            av_ff <= cv_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff    <= q_in;
            cc_ff   <= dc[CARRY_W+MW-1:MW];
            term_ff <= q_ff;
            ac_ff   <= {cc_ff[X_LO +: MW], pos_in, neg_in, cc_ff[SIDE_W-1:0]};
         end
      end

      assign st_valid[k] = av_ff;
      assign st_term[k]  = term_ff;
      assign st_carry[k] = ac_ff;
   end

   // Combine the two partial sums.
   assign diff_in = st_carry[EXP_TERMS][POS_LO +: MW] - st_carry[EXP_TERMS][NEG_LO +: MW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= st_valid[EXP_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff  <= diff_in;
         dside_ff <= st_carry[EXP_TERMS][SIDE_W-1:0];
      end
   end

   // Raise to the 64th power by repeated squaring.
   assign sq_valid[0] = dv_ff;
   assign sq_e[0]     = diff_ff;
   assign sq_side[0]  = dside_ff;

   for (genvar j = 0; j < EXP_SQUARES; j++) begin : g_square
      ske_mul #(.SHIFT(EP), .SIDE_W(SIDE_W)) u_sq (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(sq_valid[j]), .a(sq_e[j]), .b(sq_e[j]), .in_side(sq_side[j]),
         .out_valid(sq_valid[j+1]), .prod(sq_e[j+1]), .out_side(sq_side[j+1])
      );
   end

   assign out_valid = sq_valid[EXP_SQUARES];
   assign e         = sq_e[EXP_SQUARES] >> (EP - IP);
   assign out_side  = sq_side[EXP_SQUARES];

endmodule

>>> sv/ske_chk.sv
`include "stationary_kernel_eval_core_defines.svh"

module ske_chk #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic                                          req_tready,
   input logic                                          rsp_tvalid,
   input logic                                          rsp_tready,
   input logic [((2 * FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int OW = FRAC_BITS + 1;

   logic [OW-1:0]        value_u;
   logic signed [OW-1:0] slope_s;
   logic                 rsp_stall;
   logic                 range_ok;

   assign value_u   = rsp_tdata[OW-1:0];
   assign slope_s   = $signed(rsp_tdata[2*OW-1:OW]);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign range_ok  = value_u <= (OW'(1) << FRAC_BITS) && slope_s <= 0
                      && slope_s >= -(1 << FRAC_BITS);

   // A stalled result holds its data.
   `SKE_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Reset empties the output.
   `SKE_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_tvalid, "result valid after reset")

   // The input is held off only by a waiting, stalled result.
   `SKE_ASSERT(a_req_stall, !req_tready |-> rsp_stall, "input stalled without cause")

   // The value stays within one and the slope within minus one and zero.
   `SKE_ASSERT(a_rsp_range, rsp_tvalid |-> range_ok, "result out of range")

endmodule

bind stationary_kernel_eval_core ske_chk #(
   .FRAC_BITS(FRAC_BITS)
) u_ske_chk (.*);

>>> bench/tb_stationary_kernel_eval_core.sv
`timescale 1ns / 1ps

module tb_stationary_kernel_eval_core;
   import ske_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int IB = INT_BITS_DEF;
   localparam int DIST_W = IB + FB;
   localparam int OUT_W = FB + 1;
   localparam int LATENCY = 119;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic [OUT_W-1:0] slope;
   } kernel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = '0;

   stationary_kernel_eval_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   kind_type model_kind = KIND_SQEXP;
   logic [DIST_W-1:0] pending_dist[$];
   kernel_result_type expected_results[$];
   int fail_count = 0;
   bit steady_phase = 1'b0;
   int idle_pct = 10;

   // floor(a*b / 2^sh) with a wide intermediate product.
   function automatic word_type mul_shift(word_type a, word_type b, int sh);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return word_type'(p >> sh);
   endfunction

   // e^-t for t in Q.40, by Taylor series on t/64 and six squarings.
   function automatic word_type exp_neg(word_type t);
      word_type term, pos, neg, e;
      term = ONE_E;
      pos = ONE_E;
      neg = '0;
      for (int k = 1; k <= 16; k++) begin
         term = mul_shift(term, t, EP) / word_type'(k);
         if (k % 2 == 1) neg += term;
         else pos += term;
      end
      e = pos - neg;
      for (int k = 0; k < 6; k++) e = mul_shift(e, e, EP);
      return e >> (EP - IP);
   endfunction

   function automatic logic [OUT_W-1:0] round_sat(word_type v);
      word_type r;
      r = (v + (word_type'(1) << (IP - FB - 1))) >> (IP - FB);
      if (r > (word_type'(1) << FB)) r = word_type'(1) << FB;
      return r[OUT_W-1:0];
   endfunction

   function automatic kernel_result_type kernel_eval(logic [DIST_W-1:0] d, kind_type kind);
      kernel_result_type res;
      word_type r, t, e, val, slope, sq;
      res = '0;
      if ((d >> FB) >= 64) return res;
      r = word_type'(d) << (IP - FB);
      case (kind)
         KIND_SQEXP: t = mul_shift(r, r, IP + 1);
         KIND_EXP:   t = r >> 1;
         KIND_MAT32: t = mul_shift(r, C_SQRT3, IP);
         default:    t = mul_shift(r, C_SQRT5, IP);
      endcase
      if (t >= LIMIT_T) return res;
      e = exp_neg(t);
      case (kind)
         KIND_SQEXP: begin
            val = e;
            slope = mul_shift(r, e, IP);
         end
         KIND_EXP: begin
            val = e;
            slope = e >> 1;
         end
         KIND_MAT32: begin
            val = mul_shift(ONE_I + t, e, IP);
            slope = mul_shift(mul_shift(C_SQRT3, t, IP), e, IP);
         end
         default: begin
            sq = mul_shift(mul_shift(r, r, IP), C_FIVE3, IP);
            val = mul_shift(ONE_I + t + sq, e, IP);
            slope = mul_shift(mul_shift(C_SQRT5, sq, IP) + mul_shift(C_FIVE3, r, IP),
                              e, IP);
         end
      endcase
      res.value = round_sat(val);
      res.slope = -round_sat(slope);
      return res;
   endfunction

   function automatic bit take_turn();
      return steady_phase || ($urandom_range(99) >= idle_pct);
   endfunction

   // Driver: presents the oldest queued distance.
   always @(negedge clock) begin
      if (!reset) begin
         if (pending_dist.size() > 0 && take_turn()) begin
            req_tvalid <= 1'b1;
            req_tdata <= 24'(pending_dist[0]);
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= take_turn();
      end
   end

   // Predictor: records the expected result of each accepted transfer.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_results.push_back(kernel_eval(pending_dist.pop_front(), model_kind));
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      kernel_result_type want;
      logic [OUT_W-1:0] got_value, got_slope;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_value = rsp_tdata[OUT_W-1:0];
         got_slope = rsp_tdata[2*OUT_W-1:OUT_W];
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: value %h slope %h", got_value, got_slope);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (got_value !== want.value) begin
               $error("kernel_value: expected %h, actual %h", want.value, got_value);
               fail_count++;
            end
            if (got_slope !== want.slope) begin
               $error("kernel_slope: expected %h, actual %h", want.slope, got_slope);
               fail_count++;
            end
         end
      end
   end

   task automatic drain();
      wait (pending_dist.size() == 0 && !req_tvalid && expected_results.size() == 0);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic set_kind(kind_type kind);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= kind;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_kind = kind;
   endtask

   // Distances mostly in the region where the kernels are nonzero.
   function automatic logic [DIST_W-1:0] random_dist();
      case ($urandom_range(9))
         0: return DIST_W'($urandom);
         1: return DIST_W'($urandom_range(255));
         default: return DIST_W'($urandom_range(12 << FB));
      endcase
   endfunction

   initial begin
      kind_type kinds[4];
      kinds = '{KIND_SQEXP, KIND_EXP, KIND_MAT32, KIND_MAT52};
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      // Directed: zero distance, tiny values, underflow edges and extremes per kernel.
      foreach (kinds[i]) begin
         set_kind(kinds[i]);
         pending_dist.push_back('0);
         pending_dist.push_back(DIST_W'(1));
         pending_dist.push_back(DIST_W'(1 << FB));
         pending_dist.push_back(DIST_W'((8 << FB) - 1));
         pending_dist.push_back(DIST_W'((64 << FB) - 1));
         pending_dist.push_back(DIST_W'(64 << FB));
         pending_dist.push_back({DIST_W{1'b1}});
         drain();
      end
      // Random phases through every kernel, one of them without idling.
      for (int ph = 0; ph < 8; ph++) begin
         set_kind(kinds[ph % 4]);
         steady_phase = (ph == 5);
         repeat (225) pending_dist.push_back(random_dist());
         drain();
      end
      steady_phase = 1'b0;
      set_kind(KIND_SQEXP);
      if (fail_count == 0) begin
         $display("stationary_kernel_eval_core test passed");
      end else begin
         $display("stationary_kernel_eval_core test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("stationary_kernel_eval_core test failed");
      $finish;
   end

endmodule
